[hw/rtl/rrpp_pkg.sv]
package rrpp_pkg;

    localparam int NUM_REGS    = 32;
    localparam int REG_AW      = 5;
    localparam int DATA_W      = 64;
    localparam int SPAN_W      = 6;
    localparam int LEN_W       = 6;
    localparam int LEVEL_W     = 9;
    localparam int STACK_DEPTH = 256;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_READ,
        S_FIN
    } t_state;

endpackage

[hw/rtl/rrpp_ram.sv]
module rrpp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/register_range_push_pop.sv]
// channel   | direction | tdata (lowest bit up)                        | tuser
// ----------+-----------+----------------------------------------------+------------
// s_axis    | in        | first_reg[4:0], span[10:5], write_value[74:11]| cmd[1:0]
// m_axis    | out       | read_value[63:0], stack_level[72:64]          | status[1:0]
//
// one command at a time; a push or pop of n registers moves one stack memory beat a cycle,
// a read passes through S_READ, and a write or refused push/pop goes straight to S_FIN
// synchronous active-low reset clears the register file valid bits, stack pointer
// and control, so no clearing pass is needed
// a waiting result does not block the next accept; the engine only holds when
// its own result finds the output register still full
module register_range_push_pop #(
    parameter int STACK_DEPTH = rrpp_pkg::STACK_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // first_reg[4:0], span[10:5], write_value[74:11], zero pad
    input  logic [rrpp_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // cmd[1:0]
    input  logic [rrpp_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // read_value[63:0], stack_level[72:64], zero pad
    output logic [rrpp_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // status[1:0]
    output logic [rrpp_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int AW = $clog2(STACK_DEPTH);
    // compare width for pointer plus run length
    localparam int CW = ((AW > rrpp_pkg::LEN_W) ? AW : rrpp_pkg::LEN_W) + 1;
    localparam int DW = rrpp_pkg::DATA_W;
    localparam int RW = rrpp_pkg::REG_AW;

    // input beat fields
    rrpp_pkg::t_cmd              in_cmd;
    logic [RW-1:0]               in_first;
    logic [rrpp_pkg::SPAN_W-1:0] in_span;
    logic [DW-1:0]               in_wval;
    logic [rrpp_pkg::SPAN_W:0]   in_span_x;
    logic [rrpp_pkg::SPAN_W:0]   in_len_x;
    logic [rrpp_pkg::LEN_W-1:0]  in_len;
    logic                        push_ok;
    logic                        pop_ok;
    logic                        accept;

    rrpp_pkg::t_state r_state;
    rrpp_pkg::t_state n_state;

    // run engine
    logic [rrpp_pkg::LEN_W-1:0] r_cnt;
    logic [rrpp_pkg::LEN_W-1:0] r_len;
    logic                       r_is_push;
    logic                       r_rinc;
    logic [RW-1:0]              r_ra;
    logic [AW-1:0]              r_sa;
    logic [AW-1:0]              r_sp;
    logic                       r_p_vld;
    logic [RW-1:0]              r_p_ra;
    logic [AW-1:0]              r_p_sa;
    logic [rrpp_pkg::NUM_REGS-1:0] r_vld;

    // pending result and output register
    rrpp_pkg::t_status          r_res_status;
    logic [DW-1:0]              r_res_val;
    logic                       r_o_vld;
    rrpp_pkg::t_status          r_o_status;
    logic [DW-1:0]              r_o_rval;
    logic [rrpp_pkg::LEVEL_W-1:0] r_o_level;

    logic issue;
    logic load_out;

    // memory ports
    logic          rf_we;
    logic [RW-1:0] rf_waddr;
    logic [DW-1:0] rf_wdata;
    logic [RW-1:0] rf_raddr;
    logic [DW-1:0] rf_q;
    logic          stk_we;
    logic [DW-1:0] stk_wdata;
    logic [DW-1:0] stk_q;

    assign in_cmd   = rrpp_pkg::t_cmd'(i_s_axis_tuser[1:0]);
    assign in_first = i_s_axis_tdata[4:0];
    assign in_span  = i_s_axis_tdata[10:5];
    assign in_wval  = i_s_axis_tdata[74:11];

    // run length: span + 1 upward, 1 - span downward (1 to 33, which fits in LEN_W bits)
    assign in_span_x = {in_span[rrpp_pkg::SPAN_W-1], in_span};
    assign in_len_x  = in_span[rrpp_pkg::SPAN_W-1]
                     ? ((rrpp_pkg::SPAN_W+1)'(1) - in_span_x)
                     : (in_span_x + (rrpp_pkg::SPAN_W+1)'(1));
    assign in_len    = in_len_x[rrpp_pkg::LEN_W-1:0];

    // two slots of slack always kept free on push
    assign push_ok = (CW'(r_sp) + CW'(in_len)) < CW'(STACK_DEPTH - 1);
    assign pop_ok  = CW'(in_len) <= CW'(r_sp);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrpp_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    unique case (in_cmd)
                        rrpp_pkg::CMD_PUSH:
                            n_state = push_ok ? rrpp_pkg::S_MOVE : rrpp_pkg::S_FIN;
                        rrpp_pkg::CMD_POP:
                            n_state = pop_ok ? rrpp_pkg::S_MOVE : rrpp_pkg::S_FIN;
                        rrpp_pkg::CMD_WRITE: n_state = rrpp_pkg::S_FIN;
                        rrpp_pkg::CMD_READ:  n_state = rrpp_pkg::S_READ;
                    endcase
                end
            end
            rrpp_pkg::S_MOVE: begin
                if (r_cnt == r_len) begin
                    n_state = rrpp_pkg::S_FIN;
                end
            end
            rrpp_pkg::S_READ: n_state = rrpp_pkg::S_FIN;
            rrpp_pkg::S_FIN: begin
                if (!r_o_vld || i_m_axis_tready) begin
                    n_state = rrpp_pkg::S_IDLE;
                end
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = (r_state == rrpp_pkg::S_IDLE);
        issue           = (r_state == rrpp_pkg::S_MOVE) && (r_cnt != r_len);
        load_out        = (r_state == rrpp_pkg::S_FIN) && (!r_o_vld || i_m_axis_tready);
    end

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    // register file: direct write on a write command, else pop writeback
    always_comb begin
        if (accept && (in_cmd == rrpp_pkg::CMD_WRITE)) begin
            rf_we    = 1'b1;
            rf_waddr = in_first;
            rf_wdata = in_wval;
        end else begin
            rf_we    = r_p_vld && !r_is_push;
            rf_waddr = r_p_ra;
            rf_wdata = stk_q;
        end
        rf_raddr = (r_state == rrpp_pkg::S_IDLE) ? in_first : r_ra;
    end

    // never-written registers read as zero
    assign stk_we    = r_p_vld && r_is_push;
    assign stk_wdata = r_vld[r_p_ra] ? rf_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrpp_pkg::S_IDLE;
            r_sp    <= '0;
            r_vld   <= '0;
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_vld <= issue;
            if (rf_we) begin
                r_vld[rf_waddr] <= 1'b1;
            end
            if (accept) begin
                if (in_cmd == rrpp_pkg::CMD_PUSH && push_ok) begin
                    r_sp <= r_sp + AW'(in_len);
                end else if (in_cmd == rrpp_pkg::CMD_POP && pop_ok) begin
                    r_sp <= r_sp - AW'(in_len);
                end
            end
            if (load_out) begin
                r_o_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cnt     <= '0;
            r_len     <= in_len;
            r_is_push <= (in_cmd == rrpp_pkg::CMD_PUSH);
            // push up and pop down step upward through the registers
            r_rinc    <= (in_cmd == rrpp_pkg::CMD_PUSH) ^ in_span[rrpp_pkg::SPAN_W-1];
            // both pop directions start at first_reg + span
            r_ra      <= (in_cmd == rrpp_pkg::CMD_POP) ? (in_first + in_span[RW-1:0])
                                                       : in_first;
            r_sa      <= (in_cmd == rrpp_pkg::CMD_POP) ? (r_sp - AW'(1)) : r_sp;
            r_res_val <= '0;
            unique case (in_cmd)
                rrpp_pkg::CMD_PUSH:
                    r_res_status <= push_ok ? rrpp_pkg::ST_OK : rrpp_pkg::ST_OVERFLOW;
                rrpp_pkg::CMD_POP:
                    r_res_status <= pop_ok ? rrpp_pkg::ST_OK : rrpp_pkg::ST_UNDERFLOW;
                rrpp_pkg::CMD_WRITE: r_res_status <= rrpp_pkg::ST_OK;
                rrpp_pkg::CMD_READ:  r_res_status <= rrpp_pkg::ST_OK;
            endcase
        end
        if (issue) begin
            r_cnt  <= r_cnt + rrpp_pkg::LEN_W'(1);
            r_ra   <= r_rinc ? (r_ra + RW'(1)) : (r_ra - RW'(1));
            r_sa   <= r_is_push ? (r_sa + AW'(1)) : (r_sa - AW'(1));
            r_p_ra <= r_ra;
            r_p_sa <= r_sa;
        end
        if (r_state == rrpp_pkg::S_READ) begin
            r_res_val <= r_vld[r_ra] ? rf_q : '0;
        end
        if (load_out) begin
            r_o_status <= r_res_status;
            r_o_rval   <= r_res_val;
            r_o_level  <= rrpp_pkg::LEVEL_W'(r_sp);
        end
    end

    rrpp_ram #(
        .WIDTH (DW),
        .DEPTH (rrpp_pkg::NUM_REGS)
    ) u_reg_file (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_raddr),
        .o_rdata (rf_q)
    );

    // push writes at the pipelined address, pop reads at the running one
    rrpp_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_save_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_p_sa),
        .i_wdata (stk_wdata),
        .i_raddr (r_sa),
        .o_rdata (stk_q)
    );

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {
        (rrpp_pkg::M_TDATA_W - DW - rrpp_pkg::LEVEL_W)'(0), r_o_level, r_o_rval
    };
    assign o_m_axis_tuser  = r_o_status;

endmodule
